/* rtl/core/assert_macros.svh */
// Assertion macros shared by the list store RTL.
// Depends on nothing; each user module must have signals named clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, skipped while rst is high.
`define PLST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset cycles included.
`define PLST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/plst_pkg.sv */
// Package for the positional list store: sizes, codes, word and control types.
// Depends on nothing; used by every module in rtl/core.
package plst_pkg;

  localparam int CAPACITY      = 16;
  localparam int PAYLOAD_WIDTH = 32;

  // Fixed field widths of the command and response words
  localparam int CMD_W   = 3;
  localparam int POS_W   = 5;
  localparam int DATA_W  = 32;
  localparam int ENTRY_W = 5;

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W   = ((COUNT_W > POS_W) ? COUNT_W : POS_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_INS_AT   = 3'd2,
    CMD_REM_HEAD = 3'd3,
    CMD_REM_TAIL = 3'd4,
    CMD_REM_AT   = 3'd5,
    CMD_DUMP     = 3'd6
  } plst_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } plst_status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } plst_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] payload;
  } cmd_word_t;

  typedef struct packed {
    plst_status_e       status;
    logic [ENTRY_W-1:0] entry_count;
    logic [DATA_W-1:0]  data_out;
    logic               last;
  } rsp_word_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;        // run the accepted command, load its single response
    logic dump_start;  // accepted dump of a non-empty list: clear dump index
    logic dump_emit;   // load the entry at the dump index, advance
    logic rd_dump;     // read port follows the dump index
  } plst_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;
    logic dump_last;
    logic slot_free;
  } plst_stat_t;

endpackage

/* rtl/core/plst_ctrl.sv */
// Controller of the positional list store: idle/dump state machine.
// Depends on plst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plst_ctrl import plst_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  logic [CMD_W-1:0] command,
  input  plst_stat_t       stat,
  output logic             cmd_ready,
  output plst_ctrl_t       ctrl
);

  plst_state_e state, state_next;
  logic        accept;
  logic        long_dump;

  assign long_dump = (command == CMD_DUMP) && !stat.count_zero;
  assign accept    = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && long_dump) begin
          state_next = S_DUMP;
        end
      end
      S_DUMP: begin
        if (stat.slot_free && stat.dump_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready       = 1'b0;
    ctrl            = '0;
    case (state)
      S_IDLE: begin
        cmd_ready       = stat.slot_free;
        ctrl.exec       = accept && !long_dump;
        ctrl.dump_start = accept && long_dump;
      end
      S_DUMP: begin
        ctrl.rd_dump   = 1'b1;
        ctrl.dump_emit = stat.slot_free;
      end
      default: ;
    endcase
  end

  `PLST_ASSERT(a_no_accept_in_dump, (state == S_DUMP) |-> !cmd_ready, "command taken during dump")
  `PLST_ASSERT(a_dump_enters, ctrl.dump_start |=> (state == S_DUMP), "dump did not start")
  `PLST_ASSERT(a_dump_leaves, (ctrl.dump_emit && stat.dump_last) |=> (state == S_IDLE),
               "dump ran past last entry")

endmodule

/* rtl/core/plst_datapath.sv */
// Datapath of the positional list store: shifting entry cells, count,
// dump index and response register. Depends on plst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plst_datapath import plst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_word_t  cmd,
  input  plst_ctrl_t ctrl,
  input  logic       rsp_ready,
  output plst_stat_t stat,
  output rsp_word_t  rsp,
  output logic       rsp_valid
);

  logic [PAYLOAD_WIDTH-1:0] entries [CAPACITY];
  logic [COUNT_W-1:0]       count, count_next;
  logic [ADDR_W-1:0]        dump_idx;
  logic [ADDR_W-1:0]        op_idx, rd_idx;
  logic [PAYLOAD_WIDTH-1:0] ins_word, rd_word;
  logic [CMP_W-1:0]         pos_ext, cnt_ext;
  logic                     count_full, do_ins, do_rem;
  plst_status_e             op_status;

  assign ins_word   = PAYLOAD_WIDTH'(cmd.payload);
  assign pos_ext    = CMP_W'(cmd.position);
  assign cnt_ext    = CMP_W'(count);
  assign count_full = (count == COUNT_W'(CAPACITY));

  // Decode the command into a slot index, an operation and a status
  always_comb begin
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    op_idx    = '0;
    op_status = STAT_OK;
    case (cmd.command)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
        if (cmd.command == CMD_INS_TAIL) begin
          op_idx = ADDR_W'(count);
        end else if (cmd.command == CMD_INS_AT) begin
          op_idx = ADDR_W'(pos_ext - CMP_W'(1));
        end
        if (count_full) begin
          op_status = STAT_FULL;
        end else if ((cmd.command == CMD_INS_AT) &&
                     ((pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1)))) begin
          op_status = STAT_BADPOS;
        end else begin
          do_ins = 1'b1;
        end
      end
      CMD_REM_HEAD, CMD_REM_TAIL, CMD_REM_AT: begin
        if (cmd.command == CMD_REM_TAIL) begin
          op_idx = ADDR_W'(count - COUNT_W'(1));
        end else if (cmd.command == CMD_REM_AT) begin
          op_idx = ADDR_W'(pos_ext - CMP_W'(1));
        end
        if (count == '0) begin
          op_status = STAT_EMPTY;
        end else if ((cmd.command == CMD_REM_AT) &&
                     ((pos_ext == '0) || (pos_ext > cnt_ext))) begin
          op_status = STAT_BADPOS;
        end else begin
          do_rem = 1'b1;
        end
      end
      CMD_DUMP: begin
        if (count == '0) begin
          op_status = STAT_EMPTY;
        end
      end
      default: op_status = STAT_OK;
    endcase
  end

  assign rd_idx  = ctrl.rd_dump ? dump_idx : op_idx;
  assign rd_word = entries[rd_idx];

  always_comb begin
    count_next = count;
    if (ctrl.exec && do_ins) begin
      count_next = count + COUNT_W'(1);
    end else if (ctrl.exec && do_rem) begin
      count_next = count - COUNT_W'(1);
    end
  end

  // From the slot up: insert shifts in from the left, remove from the right
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [PAYLOAD_WIDTH-1:0] prev_word, succ_word;

    if (i == 0) begin : g_first
      assign prev_word = ins_word;
    end else begin : g_inner_prev
      assign prev_word = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign succ_word = entries[i];
    end else begin : g_inner_succ
      assign succ_word = entries[i+1];
    end

    always_ff @(posedge clk) begin
      if (ctrl.exec && do_ins && (ADDR_W'(i) >= op_idx)) begin
        entries[i] <= (ADDR_W'(i) == op_idx) ? ins_word : prev_word;
      end else if (ctrl.exec && do_rem && (ADDR_W'(i) >= op_idx)) begin
        entries[i] <= succ_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dump_idx  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (ctrl.dump_start) begin
        dump_idx <= '0;
      end else if (ctrl.dump_emit) begin
        dump_idx <= dump_idx + ADDR_W'(1);
      end
      if (ctrl.exec || ctrl.dump_emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      rsp.status      <= op_status;
      rsp.entry_count <= ENTRY_W'(count_next);
      rsp.data_out    <= do_rem ? DATA_W'(rd_word) : '0;
      rsp.last        <= 1'b1;
    end else if (ctrl.dump_emit) begin
      rsp.status      <= STAT_OK;
      rsp.entry_count <= ENTRY_W'(count);
      rsp.data_out    <= DATA_W'(rd_word);
      rsp.last        <= stat.dump_last;
    end
  end

  assign stat.count_zero = (count == '0);
  assign stat.dump_last  = ((COUNT_W'(dump_idx) + COUNT_W'(1)) == count);
  assign stat.slot_free  = !rsp_valid || rsp_ready;

  `PLST_ASSERT(a_count_bound, count <= COUNT_W'(CAPACITY), "count above capacity")
  `PLST_ASSERT(a_count_step, 1'b1 |=> ((count == $past(count)) ||
               (count == $past(count) + COUNT_W'(1)) ||
               (count + COUNT_W'(1) == $past(count))), "count moved by more than one")
  `PLST_ASSERT(a_dump_in_range, ctrl.rd_dump |-> (COUNT_W'(dump_idx) < count),
               "dump index beyond stored entries")
  `PLST_ASSERT(a_load_free, (ctrl.exec || ctrl.dump_emit) |-> stat.slot_free,
               "response overwritten before taken")

endmodule

/* rtl/core/positional_list_store_unit.sv */
// Top level of the positional list store: controller plus datapath.
// Depends on plst_pkg, plst_ctrl and plst_datapath.

// A bounded ordered list of up to CAPACITY payload words kept in a chain of
// shifting cells. Each command word inserts at the head, tail or a 1-based
// position, removes at the head, tail or a position, or dumps the list. An
// insert or remove shifts the whole chain at once, so every command but
// a non-empty dump yields one response word with last set; back-to-back
// commands flow at one per cycle while rsp_ready is high and no dump runs.
// A dump of N entries streams N response words in list order, one per
// cycle while rsp_ready is high, with last on the final one, and takes no
// new command until the final word is loaded; one read port walks the cells.
// Status codes: ok, full (insert with CAPACITY entries), empty (remove or
// dump with no entries), bad position (outside 1..count+1 for insert at,
// 1..count for remove at). entry_count is the count after the command. A
// response register sits between the sides, so a new command is taken while
// the previous response is being consumed. Reset is synchronous, active high,
// and leaves the list empty; no clearing pass is needed.
module positional_list_store_unit import plst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_word_t cmd,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  output rsp_word_t rsp,
  output logic      rsp_valid,
  input  logic      rsp_ready
);

  plst_ctrl_t ctrl;
  plst_stat_t stat;

  // Sequence commands and dump streaming
  plst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .command   (cmd.command),
    .stat      (stat),
    .cmd_ready (cmd_ready),
    .ctrl      (ctrl)
  );

  // Hold entries, count and the response word
  plst_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ctrl      (ctrl),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .rsp       (rsp),
    .rsp_valid (rsp_valid)
  );

endmodule
